/* hdl/atsp_pkg.sv */
// Shared types and constants for the ADIF tag stream parser.
// Used by every module of the block; depends on nothing.
`default_nettype none

package atsp_pkg;

  // Parse phases of the back end
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_GAP   = 3'd1,
    PH_NAME  = 3'd2,
    PH_LEN   = 3'd3,
    PH_TYPE  = 3'd4,
    PH_VALUE = 3'd5
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Characters the parser looks for
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_R     = 8'h72;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  // Classified input item as it travels through the queue
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] lower;
    logic       sof;
    logic       space;
    logic       lt;
    logic       gt;
    logic       colon;
    logic       digit;
    logic [3:0] digit_val;
  } item_t;

endpackage

`default_nettype wire

/* hdl/atsp_front.sv */
// Front end: takes input bytes and classifies them for the parser.
// Depends on atsp_pkg.
`default_nettype none

module atsp_front (
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_byte,
  input  wire logic          start_of_file,
  input  wire logic          queue_full,
  output logic               in_stall,
  output logic               push,
  output atsp_pkg::item_t    item
);

  // Accept whenever the queue has room
  assign in_stall = queue_full;
  assign push     = in_valid & ~queue_full;

  // Byte classification
  always_comb begin
    item           = '0;
    item.raw       = in_byte;
    item.sof       = start_of_file;
    item.lower     = (in_byte inside {[8'h41:8'h5A]}) ? (in_byte + 8'h20) : in_byte;
    item.space     = (in_byte == 8'h20) || (in_byte inside {[8'h09:8'h0D]});
    item.lt        = (in_byte == atsp_pkg::CH_LT);
    item.gt        = (in_byte == atsp_pkg::CH_GT);
    item.colon     = (in_byte == atsp_pkg::CH_COLON);
    item.digit     = (in_byte inside {[8'h30:8'h39]});
    item.digit_val = in_byte[3:0];
  end

endmodule

`default_nettype wire

/* hdl/atsp_queue.sv */
// Short FIFO of classified items between the front and back ends.
// Depends on atsp_pkg.
`default_nettype none

module atsp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire atsp_pkg::item_t   push_item,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output atsp_pkg::item_t        head_item
);

  atsp_pkg::item_t                    entries [atsp_pkg::QUEUE_DEPTH];
  logic [atsp_pkg::QPTR_BITS-1:0]     wr_ptr;
  logic [atsp_pkg::QPTR_BITS-1:0]     rd_ptr;
  logic [atsp_pkg::QCNT_BITS-1:0]     count;
  logic                               do_pop;

  assign full       = (count == atsp_pkg::QCNT_BITS'(atsp_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign do_pop     = pop & head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + atsp_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + atsp_pkg::QPTR_BITS'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + atsp_pkg::QCNT_BITS'(1);
        2'b01:   count <= count - atsp_pkg::QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/atsp_back.sv */
// Back end: tag parser state machine and the output register.
// Depends on atsp_pkg; fed by atsp_queue.
`default_nettype none

module atsp_back #(
  parameter int LEN_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire atsp_pkg::item_t   head_item,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             kind,
  output logic [7:0]             data,
  output logic                   ends_field,
  output logic                   in_header,
  output logic                   deliver,
  output logic                   end_of_record
);

  // Parser state
  atsp_pkg::phase_t      phase, phase_next;
  logic                  header, header_next;
  logic [LEN_BITS-1:0]   len_acc, len_acc_next;
  logic                  len_bad, len_bad_next;
  logic [LEN_BITS-1:0]   remaining, remaining_next;
  logic [2:0]            name_count, name_count_next;
  logic                  eoh_match, eoh_match_next;
  logic                  eor_match, eor_match_next;

  // State as seen by this item (start of file restores reset values)
  atsp_pkg::phase_t      e_phase;
  logic                  e_header;
  logic [LEN_BITS-1:0]   e_len_acc;
  logic                  e_len_bad;
  logic [LEN_BITS-1:0]   e_remaining;
  logic [2:0]            e_name_count;
  logic                  e_eoh_match;
  logic                  e_eor_match;

  atsp_pkg::item_t       it;
  logic [LEN_BITS-1:0]   rem_dec;
  logic [LEN_BITS+3:0]   len_mul;
  logic [LEN_BITS-1:0]   close_len;
  logic [7:0]            exp_eoh;
  logic [7:0]            exp_eor;
  logic                  is_eoh;

  // Result of this item
  logic                  res_valid;
  logic [1:0]            res_kind;
  logic [7:0]            res_data;
  logic                  res_ends;
  logic                  res_deliver;

  assign it = head_item;

  always_comb begin
    e_phase      = it.sof ? atsp_pkg::PH_START : phase;
    e_header     = it.sof ? 1'b0 : header;
    e_len_acc    = it.sof ? '0 : len_acc;
    e_len_bad    = it.sof ? 1'b0 : len_bad;
    e_remaining  = it.sof ? '0 : remaining;
    e_name_count = it.sof ? 3'd0 : name_count;
    e_eoh_match  = it.sof ? 1'b1 : eoh_match;
    e_eor_match  = it.sof ? 1'b1 : eor_match;
  end

  // Shared datapath pieces
  assign rem_dec   = e_remaining - {{(LEN_BITS-1){1'b0}}, 1'b1};
  assign len_mul   = ({4'b0, e_len_acc} << 3) + ({4'b0, e_len_acc} << 1)
                   + {{LEN_BITS{1'b0}}, it.digit_val};
  assign close_len = e_len_bad ? '0 : e_len_acc;
  assign is_eoh    = (e_name_count == 3'd3) && e_eoh_match;

  // Expected letters at the current name position
  always_comb begin
    case (e_name_count[1:0])
      2'd0: begin
        exp_eoh = atsp_pkg::CH_E;
        exp_eor = atsp_pkg::CH_E;
      end
      2'd1: begin
        exp_eoh = atsp_pkg::CH_O;
        exp_eor = atsp_pkg::CH_O;
      end
      default: begin
        exp_eoh = atsp_pkg::CH_H;
        exp_eor = atsp_pkg::CH_R;
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_next      = e_phase;
    header_next     = e_header;
    len_acc_next    = e_len_acc;
    len_bad_next    = e_len_bad;
    remaining_next  = e_remaining;
    name_count_next = e_name_count;
    eoh_match_next  = e_eoh_match;
    eor_match_next  = e_eor_match;
    if (e_phase == atsp_pkg::PH_VALUE) begin
      remaining_next = rem_dec;
      if (rem_dec == '0) begin
        phase_next = atsp_pkg::PH_GAP;
      end
    end else if (!it.space) begin
      case (e_phase)
        atsp_pkg::PH_START: begin
          if (it.lt) begin
            header_next     = 1'b0;
            phase_next      = atsp_pkg::PH_NAME;
            name_count_next = 3'd0;
            eoh_match_next  = 1'b1;
            eor_match_next  = 1'b1;
          end else begin
            header_next = 1'b1;
            phase_next  = atsp_pkg::PH_GAP;
          end
        end
        atsp_pkg::PH_GAP: begin
          if (it.lt) begin
            phase_next      = atsp_pkg::PH_NAME;
            name_count_next = 3'd0;
            eoh_match_next  = 1'b1;
            eor_match_next  = 1'b1;
          end
        end
        atsp_pkg::PH_NAME: begin
          if (it.colon) begin
            phase_next   = atsp_pkg::PH_LEN;
            len_acc_next = '0;
            len_bad_next = 1'b0;
          end else if (it.gt) begin
            phase_next = atsp_pkg::PH_GAP;
            if (e_header && is_eoh) begin
              header_next = 1'b0;
            end
          end else begin
            if (e_name_count < 3'd3) begin
              if (it.lower != exp_eoh) eoh_match_next = 1'b0;
              if (it.lower != exp_eor) eor_match_next = 1'b0;
            end else begin
              eoh_match_next = 1'b0;
              eor_match_next = 1'b0;
            end
            if (e_name_count < 3'd7) begin
              name_count_next = e_name_count + 3'd1;
            end
          end
        end
        atsp_pkg::PH_LEN, atsp_pkg::PH_TYPE: begin
          if (it.gt) begin
            if (close_len != '0) begin
              remaining_next = close_len;
              phase_next     = atsp_pkg::PH_VALUE;
            end else begin
              phase_next = atsp_pkg::PH_GAP;
            end
          end else if (e_phase == atsp_pkg::PH_LEN) begin
            if (it.colon) begin
              phase_next = atsp_pkg::PH_TYPE;
            end else if (it.digit) begin
              if (!e_len_bad) begin
                if (len_mul[LEN_BITS+3:LEN_BITS] != 4'd0) begin
                  len_bad_next = 1'b1;
                end else begin
                  len_acc_next = len_mul[LEN_BITS-1:0];
                end
              end
            end else begin
              len_bad_next = 1'b1;
            end
          end
        end
        default: begin
          phase_next = atsp_pkg::PH_START;
        end
      endcase
    end
  end

  // Result of this item
  always_comb begin
    res_valid   = 1'b0;
    res_kind    = atsp_pkg::KIND_NAME;
    res_data    = 8'd0;
    res_ends    = 1'b0;
    res_deliver = 1'b0;
    if (e_phase == atsp_pkg::PH_VALUE) begin
      res_valid = 1'b1;
      res_kind  = atsp_pkg::KIND_VALUE;
      res_data  = it.raw;
      if (rem_dec == '0) begin
        res_ends    = 1'b1;
        res_deliver = ~e_header;
      end
    end else if (!it.space) begin
      case (e_phase)
        atsp_pkg::PH_NAME: begin
          if (it.gt) begin
            res_valid   = 1'b1;
            res_kind    = atsp_pkg::KIND_END;
            res_ends    = 1'b1;
            res_deliver = ~(e_header && is_eoh);
          end else if (!it.colon) begin
            res_valid = 1'b1;
            res_kind  = atsp_pkg::KIND_NAME;
            res_data  = it.lower;
          end
        end
        atsp_pkg::PH_LEN, atsp_pkg::PH_TYPE: begin
          if (it.gt && (close_len == '0)) begin
            res_valid   = 1'b1;
            res_kind    = atsp_pkg::KIND_END;
            res_ends    = 1'b1;
            res_deliver = ~e_header;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // Items without a result need no room in the output register
  assign pop = head_valid & (~out_valid | ~out_stall | ~res_valid);

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= atsp_pkg::PH_START;
      header     <= 1'b0;
      len_acc    <= '0;
      len_bad    <= 1'b0;
      remaining  <= '0;
      name_count <= 3'd0;
      eoh_match  <= 1'b1;
      eor_match  <= 1'b1;
    end else if (pop) begin
      phase      <= phase_next;
      header     <= header_next;
      len_acc    <= len_acc_next;
      len_bad    <= len_bad_next;
      remaining  <= remaining_next;
      name_count <= name_count_next;
      eoh_match  <= eoh_match_next;
      eor_match  <= eor_match_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      kind          <= res_kind;
      data          <= res_data;
      ends_field    <= res_ends;
      in_header     <= header_next;
      deliver       <= res_deliver;
      end_of_record <= res_ends & (e_name_count == 3'd3) & e_eor_match;
    end
  end

endmodule

`default_nettype wire

/* hdl/adif_tag_stream_parser_core.sv */
// ADIF tag stream parser, top level: front classifier, item queue, back parser.
// Throughput: one byte per cycle; a new item is taken every cycle while the
// four-entry queue has room. in_stall rises only once four items wait behind a
// stalled result. Each accepted byte is written into the queue at the accepting
// edge; the parser steps items from the queue head and stores each result in the
// output register. Reset (rst, synchronous): queue empty, parser in start phase.
// Depends on atsp_pkg, atsp_front, atsp_queue, atsp_back.
`default_nettype none

module adif_tag_stream_parser_core #(
  parameter int LEN_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       start_of_file,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      data,
  output logic            ends_field,
  output logic            in_header,
  output logic            deliver,
  output logic            end_of_record
);

  atsp_pkg::item_t push_item;
  atsp_pkg::item_t head_item;
  logic            push;
  logic            pop;
  logic            queue_full;
  logic            head_valid;

  // Classify incoming bytes
  atsp_front u_front (
    .in_valid      (in_valid),
    .in_byte       (in_byte),
    .start_of_file (start_of_file),
    .queue_full    (queue_full),
    .in_stall      (in_stall),
    .push          (push),
    .item          (push_item)
  );

  // Decoupling queue
  atsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Tag parser and output register
  atsp_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .data          (data),
    .ends_field    (ends_field),
    .in_header     (in_header),
    .deliver       (deliver),
    .end_of_record (end_of_record)
  );

endmodule

`default_nettype wire
